// ----- rtl/kmf_pkg.sv -----
// ----------------------------------------------------------------------------
// kmf_pkg: shared types and constants of the Kuramoto mean-field stepper
// Register indexes, fixed-point constants and the controller/datapath link.
// ----------------------------------------------------------------------------
package kmf_pkg;

    localparam int MAX_OSC  = 1024;
    localparam int MAX_RUN  = 64;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int RUN_W    = 7;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_OSC_COUNT  = 2'd0;
    localparam logic [1:0] CFG_COUPLING   = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd2;
    localparam logic [1:0] CFG_RUN_LENGTH = 2'd3;

    // reset values
    localparam logic [10:0] OSC_COUNT_RST  = 11'd1;
    localparam logic [15:0] TIME_STEP_RST  = 16'd655;
    localparam logic [6:0]  RUN_LENGTH_RST = 7'd1;

    // 2^30 / pi
    localparam logic signed [29:0] INV_PI_Q30 = 30'sd341782638;
    // quarter turn and full-scale order parameter
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [15:0] R_MAX        = 16'd32768;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_READ,
        DP_TRIG_OLD,
        DP_TRIG_NEW,
        DP_MUL_Q,
        DP_DIV_Q,
        DP_KMUL,
        DP_COUP,
        DP_RAD,
        DP_NEWPH,
        DP_ACC,
        DP_CLR,
        DP_COMMIT,
        DP_SQ,
        DP_SQRT,
        DP_DIV_R,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] idx;
        logic [5:0]       step;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        logic             trig_done;
        logic             div_done;
        logic             sqrt_done;
        logic             sums_valid;
        logic             out_free;
        logic [CNT_W-1:0] n_act;
        logic [RUN_W-1:0] runs;
    } dp_stat_t;

endpackage

// ----- rtl/kmf_trig.sv -----
// ----------------------------------------------------------------------------
// kmf_trig: polynomial sine in Q15
// Stepped sequence on one shared product, one multiplication a cycle, result signed 17 bits.
// ----------------------------------------------------------------------------
module kmf_trig
    import kmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [16:0] y
);

    logic [2:0]  cnt_reg;
    logic        done_reg;
    logic [14:0] z_reg;
    logic        neg_reg;
    logic [14:0] x2_reg;
    logic [15:0] t_reg;
    logic signed [16:0] y_reg;

    logic [14:0] z_next;
    logic [31:0] prod;
    logic [16:0] y_mag;

    // fold the angle into the first quadrant
    always_comb
    begin
        if (angle[14])
            z_next = 15'd16384 - {1'b0, angle[13:0]};
        else
            z_next = {1'b0, angle[13:0]};
    end

    // share one product between the steps
    always_comb
    begin
        case (cnt_reg)
            3'd1:    prod = {17'b0, z_reg} * {17'b0, z_reg};
            3'd2:    prod = 32'd2320 * {17'b0, x2_reg};
            3'd3:    prod = (32'd21024 - {16'b0, t_reg}) * {17'b0, x2_reg};
            3'd4:    prod = (32'd51472 - {16'b0, t_reg}) * {17'b0, z_reg};
            default: prod = 32'd0;
        endcase
    end

    assign y_mag = prod[30:14];

    // advance the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= 3'd1;
            else if (cnt_reg == 3'd4)
            begin
                cnt_reg  <= 3'd0;
                done_reg <= 1'b1;
            end
            else if (cnt_reg != 3'd0)
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    // hold the intermediate terms
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            z_reg   <= z_next;
            neg_reg <= angle[15];
        end
        case (cnt_reg)
            3'd1:    x2_reg <= prod[28:14];
            3'd2:    t_reg  <= prod[29:14];
            3'd3:    t_reg  <= prod[29:14];
            3'd4:    y_reg  <= neg_reg ? -$signed(y_mag) : $signed(y_mag);
            default: ;
        endcase
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ----- rtl/kmf_div.sv -----
// ----------------------------------------------------------------------------
// kmf_div: bit-serial divider by the oscillator count
// Restoring division of a 42-bit magnitude, one quotient bit a cycle,
// signed result truncated toward zero.
// ----------------------------------------------------------------------------
module kmf_div
    import kmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [41:0]        dividend,
    input  logic               neg,
    input  logic [CNT_W-1:0]   divisor,
    output logic               done,
    output logic signed [42:0] quot
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [10:0]      rem_reg;
    logic [41:0]      q_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic             neg_reg;
    logic signed [42:0] res_reg;

    logic [11:0] sh;
    logic        bit_q;
    logic [11:0] diff;
    logic [41:0] q_next;

    // one restoring step
    always_comb
    begin
        sh     = {rem_reg, q_reg[41]};
        diff   = sh - {1'b0, dvs_reg};
        bit_q  = (sh >= {1'b0, dvs_reg});
        q_next = {q_reg[40:0], bit_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd41)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the quotient in and apply the sign at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 11'd0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? diff[10:0] : sh[10:0];
            q_reg   <= q_next;
            if (cnt_reg == 6'd41)
                res_reg <= neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
        end
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule

// ----- rtl/kmf_isqrt.sv -----
// ----------------------------------------------------------------------------
// kmf_isqrt: integer square root
// Digit-by-digit root of a 52-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module kmf_isqrt
    import kmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [51:0] value,
    output logic        done,
    output logic [25:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [51:0] v_reg;
    logic [51:0] r_reg;
    logic [51:0] bit_reg;
    logic [51:0] rb;

    assign rb = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // try the next bit of the root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= 52'd0;
            bit_reg <= 52'd1 << 50;
        end
        else if (busy_reg)
        begin
            if (v_reg >= rb)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[25:0];

endmodule

// ----- rtl/kmf_dpath.sv -----
// ----------------------------------------------------------------------------
// kmf_dpath: datapath of the Kuramoto stepper
// Configuration, oscillator stores, trig, division, root and output register.
// ----------------------------------------------------------------------------
module kmf_dpath
    import kmf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [23:0]             cfg_wdata,
    input  logic [IDX_W-1:0]        load_idx,
    input  logic signed [15:0]      load_phase,
    input  logic signed [23:0]      load_freq,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             order_parameter,
    output logic [5:0]              step_number,
    output logic                    last
);

    logic [10:0] osc_count_reg;
    logic [23:0] gain_reg;
    logic [15:0] dt_reg;
    logic [6:0]  run_len_reg;
    logic        sums_valid_reg;

    logic [15:0] phase_mem [MAX_OSC];
    logic [23:0] freq_mem  [MAX_OSC];
    logic [15:0] rd_phase_reg;
    logic signed [23:0] rd_freq_reg;

    logic signed [26:0] cos_sum_reg;
    logic signed [26:0] sin_sum_reg;
    logic signed [26:0] nc_reg;
    logic signed [26:0] ns_reg;
    logic signed [43:0] p1_reg;
    logic signed [43:0] p2_reg;
    logic [39:0]        kl_reg;
    logic signed [41:0] kh_reg;
    logic signed [27:0] coup_reg;
    logic signed [29:0] rad_reg;
    logic [15:0]        newph_reg;
    logic [51:0]        sqc_reg;
    logic [51:0]        sqs_reg;

    logic        out_valid_reg;
    logic [15:0] order_reg;
    logic [5:0]  step_reg;
    logic        last_reg;

    logic [CNT_W-1:0]   n_act;
    logic [RUN_W-1:0]   runs;
    logic [15:0]        angle_sel;
    logic               trig_start;
    logic               sin_done;
    logic               cos_done;
    logic signed [16:0] sin_y;
    logic signed [16:0] cos_y;
    logic signed [44:0] diff;
    logic [44:0]        diff_mag;
    logic               div_start;
    logic [41:0]        div_in;
    logic               div_neg;
    logic               div_done;
    logic signed [42:0] div_q;
    logic               sqrt_done;
    logic [25:0]        root;
    logic signed [57:0] full;
    logic signed [28:0] d_sum;
    logic signed [45:0] d_prod;
    logic signed [59:0] ph_prod;
    logic signed [53:0] sqc;
    logic signed [53:0] sqs;
    logic [IDX_W-1:0]   wr_addr;
    logic [15:0]        wr_phase;
    logic [23:0]        wr_freq;
    logic               wr_en;
    logic               wr_freq_en;
    logic [15:0]        r_cap;

    // clamp count and run length to their working ranges
    always_comb
    begin
        if (osc_count_reg == 11'd0)
            n_act = 11'd1;
        else if (osc_count_reg > 11'd1024)
            n_act = 11'd1024;
        else
            n_act = osc_count_reg;
        if (run_len_reg == 7'd0)
            runs = 7'd1;
        else if (run_len_reg > 7'd64)
            runs = 7'd64;
        else
            runs = run_len_reg;
    end

    // configuration registers, the sums flag and the committed sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_count_reg  <= OSC_COUNT_RST;
            gain_reg       <= 24'd0;
            dt_reg         <= TIME_STEP_RST;
            run_len_reg    <= RUN_LENGTH_RST;
            sums_valid_reg <= 1'b0;
            cos_sum_reg    <= 27'sd0;
            sin_sum_reg    <= 27'sd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OSC_COUNT:  osc_count_reg <= cfg_wdata[10:0];
                    CFG_COUPLING:   gain_reg    <= cfg_wdata;
                    CFG_TIME_STEP:  dt_reg      <= cfg_wdata[15:0];
                    CFG_RUN_LENGTH: run_len_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            // drop the sums on a load or a new count
            if ((cmd.op == DP_LOAD) || (cfg_we && (cfg_index == CFG_OSC_COUNT)))
                sums_valid_reg <= 1'b0;
            else if (cmd.op == DP_COMMIT)
            begin
                sums_valid_reg <= 1'b1;
                cos_sum_reg    <= nc_reg;
                sin_sum_reg    <= ns_reg;
            end
        end
    end

    // one write port shared by loads and phase updates
    always_comb
    begin
        wr_en      = (cmd.op == DP_LOAD) || (cmd.op == DP_NEWPH);
        wr_freq_en = (cmd.op == DP_LOAD);
        wr_addr    = (cmd.op == DP_LOAD) ? load_idx : cmd.idx;
        wr_phase   = (cmd.op == DP_LOAD) ? load_phase : newph_reg;
        wr_freq    = load_freq;
        ph_prod    = rad_reg * INV_PI_Q30;
        if (cmd.op == DP_NEWPH)
            wr_phase = rd_phase_reg + ph_prod[46:31];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            phase_mem[wr_addr] <= wr_phase;
        if (wr_freq_en)
            freq_mem[wr_addr] <= wr_freq;
        if (cmd.op == DP_READ)
        begin
            rd_phase_reg <= phase_mem[cmd.idx];
            rd_freq_reg  <= freq_mem[cmd.idx];
        end
    end

    // sine and cosine lanes
    assign trig_start = (cmd.op == DP_TRIG_OLD) || (cmd.op == DP_TRIG_NEW);
    assign angle_sel  = (cmd.op == DP_TRIG_NEW) ? newph_reg : rd_phase_reg;

    kmf_trig u_sin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (angle_sel),
        .done  (sin_done),
        .y     (sin_y)
    );

    kmf_trig u_cos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (angle_sel + QUARTER_TURN),
        .done  (cos_done),
        .y     (cos_y)
    );

    // shared divider
    always_comb
    begin
        diff     = $signed({p1_reg[43], p1_reg}) - $signed({p2_reg[43], p2_reg});
        diff_mag = diff[44] ? 45'(-diff) : 45'(diff);
        div_start = (cmd.op == DP_DIV_Q) || (cmd.op == DP_DIV_R);
        if (cmd.op == DP_DIV_R)
        begin
            div_in  = {16'd0, root};
            div_neg = 1'b0;
        end
        else
        begin
            div_in  = diff_mag[41:0];
            div_neg = diff[44];
        end
    end

    kmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .neg      (div_neg),
        .divisor  (n_act),
        .done     (div_done),
        .quot     (div_q)
    );

    kmf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == DP_SQRT),
        .value (sqc_reg + sqs_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    // arithmetic between the stages
    always_comb
    begin
        full   = $signed({kh_reg, 16'd0}) + $signed({18'd0, kl_reg});
        d_sum  = $signed({{5{rd_freq_reg[23]}}, rd_freq_reg}) + $signed({coup_reg[27], coup_reg});
        d_prod = d_sum * $signed({1'b0, dt_reg});
        sqc    = nc_reg * nc_reg;
        sqs    = ns_reg * ns_reg;
        if (div_q > 43'sd32768)
            r_cap = R_MAX;
        else
            r_cap = div_q[15:0];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_MUL_Q:
            begin
                p1_reg <= sin_sum_reg * cos_y;
                p2_reg <= cos_sum_reg * sin_y;
            end
            DP_KMUL:
            begin
                kl_reg <= gain_reg * div_q[15:0];
                kh_reg <= $signed({1'b0, gain_reg}) * $signed(div_q[32:16]);
            end
            DP_COUP:  coup_reg  <= full[57:30];
            DP_RAD:   rad_reg   <= d_prod[45:16];
            DP_NEWPH: newph_reg <= wr_phase;
            DP_CLR:
            begin
                nc_reg <= 27'sd0;
                ns_reg <= 27'sd0;
            end
            DP_ACC:
            begin
                nc_reg <= nc_reg + {{10{cos_y[16]}}, cos_y};
                ns_reg <= ns_reg + {{10{sin_y[16]}}, sin_y};
            end
            DP_SQ:
            begin
                sqc_reg <= sqc[51:0];
                sqs_reg <= sqs[51:0];
            end
            default: ;
        endcase
    end

    // output register: one result waits here while the next step runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_EMIT)
        begin
            order_reg <= r_cap;
            step_reg  <= cmd.step;
            last_reg  <= cmd.last;
        end
    end

    always_comb
    begin
        stat.trig_done  = sin_done & cos_done;
        stat.div_done   = div_done;
        stat.sqrt_done  = sqrt_done;
        stat.sums_valid = sums_valid_reg;
        stat.out_free   = !out_valid_reg;
        stat.n_act      = n_act;
        stat.runs       = runs;
    end

    assign out_valid       = out_valid_reg;
    assign order_parameter = order_reg;
    assign step_number     = step_reg;
    assign last            = last_reg;

endmodule

// ----- rtl/kmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmf_ctrl: sequencer of the Kuramoto stepper
// Walks the oscillators once per sums pass and once per Euler step.
// ----------------------------------------------------------------------------
module kmf_ctrl
    import kmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     mode,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, F_CLR, F_RD, F_TRIG, F_TW, F_ACC, F_COMMIT,
        U_CLR, U_RD, U_TRIG, U_TW, U_MUL, U_DIV, U_DW, U_KMUL, U_COUP,
        U_RAD, U_NEWPH, U_TRIG2, U_TW2, U_ACC, U_COMMIT, U_SQ, U_SQRT,
        U_QW, U_DIVR, U_RW, U_EMIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [RUN_W-1:0] step_reg;
    logic             last_osc;
    logic             last_step;

    assign last_osc  = ({1'b0, idx_reg} + 11'd1) == stat.n_act;
    assign last_step = (step_reg + 7'd1) == stat.runs;
    assign in_ready  = (state_reg == S_IDLE);

    // decode the state into a datapath command
    always_comb
    begin
        cmd.idx  = idx_reg;
        cmd.step = step_reg[5:0];
        cmd.last = last_step;
        case (state_reg)
            S_IDLE:   cmd.op = (in_valid && !mode) ? DP_LOAD : DP_NOP;
            F_CLR:    cmd.op = DP_CLR;
            F_RD:     cmd.op = DP_READ;
            F_TRIG:   cmd.op = DP_TRIG_OLD;
            F_ACC:    cmd.op = DP_ACC;
            F_COMMIT: cmd.op = DP_COMMIT;
            U_CLR:    cmd.op = DP_CLR;
            U_RD:     cmd.op = DP_READ;
            U_TRIG:   cmd.op = DP_TRIG_OLD;
            U_MUL:    cmd.op = DP_MUL_Q;
            U_DIV:    cmd.op = DP_DIV_Q;
            U_KMUL:   cmd.op = DP_KMUL;
            U_COUP:   cmd.op = DP_COUP;
            U_RAD:    cmd.op = DP_RAD;
            U_NEWPH:  cmd.op = DP_NEWPH;
            U_TRIG2:  cmd.op = DP_TRIG_NEW;
            U_ACC:    cmd.op = DP_ACC;
            U_COMMIT: cmd.op = DP_COMMIT;
            U_SQ:     cmd.op = DP_SQ;
            U_SQRT:   cmd.op = DP_SQRT;
            U_DIVR:   cmd.op = DP_DIV_R;
            U_EMIT:   cmd.op = stat.out_free ? DP_EMIT : DP_NOP;
            default:  cmd.op = DP_NOP;
        endcase
    end

    // advance the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg  <= '0;
                    step_reg <= '0;
                    if (in_valid && mode)
                        state_reg <= stat.sums_valid ? U_CLR : F_CLR;
                end
                F_CLR:    state_reg <= F_RD;
                F_RD:     state_reg <= F_TRIG;
                F_TRIG:   state_reg <= F_TW;
                F_TW:     if (stat.trig_done) state_reg <= F_ACC;
                F_ACC:
                begin
                    if (last_osc)
                        state_reg <= F_COMMIT;
                    else
                    begin
                        idx_reg   <= idx_reg + 10'd1;
                        state_reg <= F_RD;
                    end
                end
                F_COMMIT:
                begin
                    idx_reg   <= '0;
                    state_reg <= U_CLR;
                end
                U_CLR:    state_reg <= U_RD;
                U_RD:     state_reg <= U_TRIG;
                U_TRIG:   state_reg <= U_TW;
                U_TW:     if (stat.trig_done) state_reg <= U_MUL;
                U_MUL:    state_reg <= U_DIV;
                U_DIV:    state_reg <= U_DW;
                U_DW:     if (stat.div_done) state_reg <= U_KMUL;
                U_KMUL:   state_reg <= U_COUP;
                U_COUP:   state_reg <= U_RAD;
                U_RAD:    state_reg <= U_NEWPH;
                U_NEWPH:  state_reg <= U_TRIG2;
                U_TRIG2:  state_reg <= U_TW2;
                U_TW2:    if (stat.trig_done) state_reg <= U_ACC;
                U_ACC:
                begin
                    if (last_osc)
                        state_reg <= U_COMMIT;
                    else
                    begin
                        idx_reg   <= idx_reg + 10'd1;
                        state_reg <= U_RD;
                    end
                end
                U_COMMIT: state_reg <= U_SQ;
                U_SQ:     state_reg <= U_SQRT;
                U_SQRT:   state_reg <= U_QW;
                U_QW:     if (stat.sqrt_done) state_reg <= U_DIVR;
                U_DIVR:   state_reg <= U_RW;
                U_RW:     if (stat.div_done) state_reg <= U_EMIT;
                U_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        idx_reg <= '0;
                        if (last_step)
                            state_reg <= S_IDLE;
                        else
                        begin
                            step_reg  <= step_reg + 7'd1;
                            state_reg <= U_CLR;
                        end
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/kuramoto_mean_field_step_top.sv -----
// ----------------------------------------------------------------------------
// kuramoto_mean_field_step_top: Kuramoto population stepper
// Load items fill the oscillator stores; a run item performs Euler steps
// with mean-field coupling and returns the order parameter of each step.
// ----------------------------------------------------------------------------
// A load item is written into the stores straight from the idle state. A run
// item first forms the cos/sin sums when they are stale, then each step walks
// every oscillator and then finishes: the bit-serial divider that scales the
// coupling term by the oscillator count sets most of the cost, the sine/cosine
// sequencer and the square root the rest. One item is worked on at a time; a
// finished result waits in the output register while the next step proceeds.
module kuramoto_mean_field_step_top
    import kmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [9:0]         osc_index,
    input  logic signed [15:0] init_phase,
    input  logic signed [23:0] natural_freq,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        order_parameter,
    output logic [5:0]         step_number,
    output logic               last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    kmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    kmf_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .load_idx        (osc_index),
        .load_phase      (init_phase),
        .load_freq       (natural_freq),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .order_parameter (order_parameter),
        .step_number     (step_number),
        .last            (last)
    );

    // a run request holds off further requests
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode) |=> !in_ready)
        else $error("request accepted while a run was starting");

    // a load invalidates the sums
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !mode) |=> !stat.sums_valid)
        else $error("sums still valid after a load");

    // the final step carries the run's last index
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_EMIT && cmd.last) |-> ({1'b0, cmd.step} + 7'd1 == stat.runs))
        else $error("last flag on the wrong step");

    // order parameter stays within full scale
    a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order_parameter <= R_MAX))
        else $error("order parameter above full scale");

endmodule
